@@ sv/ttb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the triangle tangent and bitangent unit.
// Depends on nothing; every other file imports it.
package ttb_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int UNIT_WIDTH = 16;
  localparam int OUT_BITS = 6 * UNIT_WIDTH;
  localparam int NORM_TOP = 30;
  localparam int FRAC_BITS = 15;
  localparam int LEN_WIDTH = 32;
  localparam int NUM_WIDTH = NORM_TOP + 1 + FRAC_BITS + 1;
  localparam int QUO_WIDTH = FRAC_BITS + 2;
  localparam int MUL_STEPS = 14;
  localparam int SQRT_STEPS = 32;
  localparam logic [UNIT_WIDTH-2:0] UNIT_MAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_CHK, S_LOAD, S_NCHK, S_NORM, S_SQ, S_SQA,
    S_SQI, S_SQRT, S_DINIT, S_DIV, S_DEND, S_DONE
  } ttb_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_VTX, OP_MUL, OP_ACC, OP_DEGEN, OP_LOAD, OP_SHIFT, OP_SQ,
    OP_SQACC, OP_SQRT_INIT, OP_SQRT, OP_DIV_INIT, OP_DIV, OP_DIV_END, OP_OUT
  } ttb_op_t;

  typedef struct packed {
    ttb_op_t    op;
    logic [3:0] idx;
    logic       vsel;
    logic [1:0] phase;
  } ttb_cmd_t;

  typedef struct packed {
    logic det_zero;
    logic vec_zero;
    logic norm_done;
  } ttb_stat_t;

endpackage

@@ sv/ttb_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer of the tangent unit: vertex slots, the product schedule,
// normalization steps and the output handshake. Depends on ttb_pkg.
module ttb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  ttb_pkg::ttb_stat_t stat,
  output ttb_pkg::ttb_cmd_t  cmd
);
  import ttb_pkg::*;

  ttb_state_t state, state_next;
  logic [5:0] cnt, cnt_next;
  logic [1:0] comp, comp_next;
  logic       vsel, vsel_next;
  logic [1:0] phase, phase_next;
  logic       load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      comp     <= '0;
      vsel     <= 1'b0;
      phase    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      vsel  <= vsel_next;
      phase <= phase_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    vsel_next  = vsel;
    phase_next = phase;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    cmd.op     = OP_NONE;
    cmd.idx    = cnt[3:0];
    cmd.vsel   = vsel;
    cmd.phase  = phase;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_VTX;
          if (phase == 2'd2) begin
            phase_next = 2'd0;
            cnt_next   = '0;
            state_next = S_MUL;
          end else if (phase == 2'd1) begin
            phase_next = 2'd2;
          end else begin
            phase_next = 2'd1;
          end
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (cnt == 6'(MUL_STEPS - 1)) begin
          state_next = S_CHK;
        end else begin
          cnt_next   = cnt + 6'd1;
          state_next = S_MUL;
        end
      end
      S_CHK: begin
        if (stat.det_zero) begin
          cmd.op     = OP_DEGEN;
          state_next = S_DONE;
        end else begin
          vsel_next  = 1'b0;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op     = OP_LOAD;
        state_next = S_NCHK;
      end
      S_NCHK: begin
        if (stat.vec_zero) begin
          cmd.op     = OP_DEGEN;
          state_next = S_DONE;
        end else begin
          state_next = S_NORM;
        end
      end
      S_NORM: begin
        cmd.op = OP_SHIFT;
        if (stat.norm_done) begin
          cnt_next   = '0;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.op     = OP_SQ;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.op = OP_SQACC;
        if (cnt == 6'd2) begin
          state_next = S_SQI;
        end else begin
          cnt_next   = cnt + 6'd1;
          state_next = S_SQ;
        end
      end
      S_SQI: begin
        cmd.op     = OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt == 6'(SQRT_STEPS - 1)) begin
          comp_next  = '0;
          state_next = S_DINIT;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_DINIT: begin
        cmd.op     = OP_DIV_INIT;
        cmd.idx    = {2'b00, comp};
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt == 6'(NUM_WIDTH - 1)) begin
          state_next = S_DEND;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      S_DEND: begin
        cmd.op  = OP_DIV_END;
        cmd.idx = {2'b00, comp};
        if (comp == 2'd2) begin
          if (!vsel) begin
            vsel_next  = 1'b1;
            state_next = S_LOAD;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_DINIT;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.op     = OP_OUT;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/ttb_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the tangent unit: vertex store, shared multiplier, accumulator,
// normalizing shifter, square root and divider. Depends on ttb_pkg.
module ttb_dp #(
  parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic [5*COORD_WIDTH-1:0]     vtx,
  input  ttb_pkg::ttb_cmd_t            cmd,
  output ttb_pkg::ttb_stat_t           stat,
  output logic [ttb_pkg::OUT_BITS-1:0] out_data,
  output logic                         out_deg
);
  import ttb_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int D  = W + 1;
  localparam int A  = 2 * D + 1;
  localparam int MW = (D > 32) ? D : 32;
  localparam int PW = 2 * MW;

  logic signed [W-1:0]  fv [5];
  logic signed [W-1:0]  sv [5];
  logic signed [W-1:0]  vin [5];
  logic signed [D-1:0]  e1 [3];
  logic signed [D-1:0]  e2 [3];
  logic signed [D-1:0]  d1u, d1v, d2u, d2v;
  logic signed [D-1:0]  opa, opb;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [A-1:0]  acc;
  logic signed [A-1:0]  vec [7];
  logic [A-1:0]         mag [3];
  logic                 mneg [3];
  logic [A-1:0]         ormag;
  logic [63:0]          sum, sx, sres, sbit, stry;
  logic [LEN_WIDTH-1:0] len;
  logic [NUM_WIDTH-1:0] dnum;
  logic [LEN_WIDTH-1:0] drem;
  logic [LEN_WIDTH:0]   dtry;
  logic [QUO_WIDTH-1:0] dq;
  logic [UNIT_WIDTH-2:0] qsat;
  logic [UNIT_WIDTH-1:0] wres [6];
  logic                 wdeg;
  logic [3:0]           kk;
  logic [1:0]           ki;
  logic [2:0]           widx;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      vin[i] = vtx[i*W +: W];
    end
  end

  assign kk = cmd.idx - 4'd2;
  assign ki = kk[3:2];

  always_comb begin
    opa = d1u;
    opb = d2v;
    if (cmd.idx == 4'd1) begin
      opa = d2u;
      opb = d1v;
    end else if (cmd.idx >= 4'd2) begin
      case (kk[1:0])
        2'd0: begin
          opa = d2v;
          opb = e1[ki];
        end
        2'd1: begin
          opa = d1v;
          opb = e2[ki];
        end
        2'd2: begin
          opa = d1u;
          opb = e2[ki];
        end
        default: begin
          opa = d2u;
          opb = e1[ki];
        end
      endcase
    end
    if (cmd.op == OP_SQ) begin
      ma = MW'($signed({1'b0, mag[cmd.idx[1:0]][NORM_TOP:0]}));
      mb = ma;
    end else begin
      ma = MW'(opa);
      mb = MW'(opb);
    end
  end

  assign ormag = mag[0] | mag[1] | mag[2];
  assign stat.det_zero = (vec[0] == '0);
  assign stat.vec_zero = (ormag == '0);
  assign stat.norm_done = (ormag[A-1:NORM_TOP+1] == '0) && ormag[NORM_TOP];

  assign len  = sres[LEN_WIDTH-1:0];
  assign stry = sres + sbit;
  assign dtry = {drem, dnum[NUM_WIDTH-1]};
  assign qsat = (dq > QUO_WIDTH'(UNIT_MAX)) ? UNIT_MAX : dq[UNIT_WIDTH-2:0];
  assign widx = cmd.vsel ? (3'd3 + 3'(cmd.idx[1:0])) : 3'(cmd.idx[1:0]);

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_VTX: begin
        if (cmd.phase == 2'd1) begin
          for (int i = 0; i < 5; i++) sv[i] <= vin[i];
        end else if (cmd.phase == 2'd2) begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= D'(sv[i]) - D'(fv[i]);
            e2[i] <= D'(vin[i]) - D'(fv[i]);
          end
          d1u  <= D'(sv[3]) - D'(fv[3]);
          d1v  <= D'(sv[4]) - D'(fv[4]);
          d2u  <= D'(vin[3]) - D'(fv[3]);
          d2v  <= D'(vin[4]) - D'(fv[4]);
          wdeg <= 1'b0;
        end else begin
          for (int i = 0; i < 5; i++) fv[i] <= vin[i];
        end
      end
      OP_MUL, OP_SQ: prod <= ma * mb;
      OP_ACC: begin
        if (!cmd.idx[0]) begin
          acc <= A'(prod);
        end else begin
          vec[cmd.idx[3:1]] <= acc - A'(prod);
        end
      end
      OP_DEGEN: begin
        wdeg <= 1'b1;
        for (int i = 0; i < 6; i++) wres[i] <= '0;
      end
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          mneg[i] <= vec[1+2*i+cmd.vsel][A-1] ^ vec[0][A-1];
          mag[i]  <= vec[1+2*i+cmd.vsel][A-1] ? A'(-vec[1+2*i+cmd.vsel])
                                              : A'(vec[1+2*i+cmd.vsel]);
        end
      end
      OP_SHIFT: begin
        if (ormag[A-1:NORM_TOP+1] != '0) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
        end else if (!ormag[NORM_TOP]) begin
          for (int i = 0; i < 3; i++) mag[i] <= mag[i] << 1;
        end
      end
      OP_SQACC: begin
        if (cmd.idx[1:0] == 2'd0) begin
          sum <= 64'(prod);
        end else begin
          sum <= sum + 64'(prod);
        end
      end
      OP_SQRT_INIT: begin
        sx   <= sum;
        sres <= '0;
        sbit <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (sx >= stry) begin
          sx   <= sx - stry;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DIV_INIT: begin
        dnum <= {1'b0, mag[cmd.idx[1:0]][NORM_TOP:0], FRAC_BITS'(0)}
                + NUM_WIDTH'(len >> 1);
        drem <= '0;
        dq   <= '0;
      end
      OP_DIV: begin
        if (dtry >= {1'b0, len}) begin
          drem <= LEN_WIDTH'(dtry - {1'b0, len});
          dq   <= {dq[QUO_WIDTH-2:0], 1'b1};
        end else begin
          drem <= dtry[LEN_WIDTH-1:0];
          dq   <= {dq[QUO_WIDTH-2:0], 1'b0};
        end
        dnum <= dnum << 1;
      end
      OP_DIV_END: begin
        wres[widx] <= mneg[cmd.idx[1:0]] ? -{1'b0, qsat} : {1'b0, qsat};
      end
      OP_OUT: begin
        out_data <= {wres[5], wres[4], wres[3], wres[2], wres[1], wres[0]};
        out_deg  <= wdeg;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/triangle_tangent_bitangent_unit.sv @@
`timescale 1ns / 1ps
// Per-triangle tangent and bitangent for a triangle-list vertex stream.
// Each input beat is one vertex; the first two beats of a triangle are stored,
// and the third starts the computation, after which one result beat follows.
// The work behind each result is fourteen products on one shared multiplier,
// a one-bit-per-cycle normalizing shift of each vector, a 32-step square root
// and three 47-step divisions per vector; a zero determinant ends it after
// the products with a degenerate result. The input is not accepted during
// that time, but a finished result may wait in the output register while new
// vertices arrive.
// Depends on ttb_pkg, ttb_ctrl and ttb_dp.
module triangle_tangent_bitangent_unit #(
  parameter int COORD_WIDTH = ttb_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_x, pos_y, pos_z, tex_u, tex_v, then zero fill to whole bytes
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // tan_x, tan_y, tan_z, bit_x, bit_y, bit_z
  output logic [ttb_pkg::OUT_BITS-1:0] m_tdata,
  // degenerate
  output logic m_tuser
);
  import ttb_pkg::*;

  ttb_cmd_t  cmd;
  ttb_stat_t stat;

  ttb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttb_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk      (clk),
    .vtx      (s_tdata[5*COORD_WIDTH-1:0]),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (m_tdata),
    .out_deg  (m_tuser)
  );

endmodule

@@ sv/ttb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the tangent unit, bound to the top level.
// Depends on ttb_pkg.
module ttb_checker (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [ttb_pkg::OUT_BITS-1:0] m_tdata,
  input logic m_tuser
);
  import ttb_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("degenerate result carries nonzero vectors");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      m_tdata[3*UNIT_WIDTH-1:0] != '0 && m_tdata[OUT_BITS-1:3*UNIT_WIDTH] != '0)
    else $error("unit vector of a valid triangle is zero");

  a_busy_before_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the input side was idle");

endmodule

bind triangle_tangent_bitangent_unit ttb_checker u_ttb_checker (.*);

@@ tb/tb_triangle_tangent_bitangent_unit.sv @@
`timescale 1ns / 1ps
// Testbench for triangle_tangent_bitangent_unit: streams triangle-list vertices,
// predicts unit tangent and bitangent per triangle and checks every result beat.
// Depends on ttb_pkg and the unit under test.
module tb_triangle_tangent_bitangent_unit;
  import ttb_pkg::*;

  localparam int CW = 32;
  localparam int DW = ((5*CW+7)/8)*8;

  typedef struct {
    logic [15:0] tan [3];
    logic [15:0] bin [3];
    logic        degen;
  } frame_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BITS-1:0] m_tdata;
  logic m_tuser;

  triangle_tangent_bitangent_unit i_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  frame_t frame_q[$];
  logic signed [CW-1:0] held_a [5];
  logic signed [CW-1:0] held_b [5];
  int slot = 0;
  int errors = 0;
  int hold_off = 0;
  int gap_max = 3;

  function automatic logic signed [131:0] flip_if(logic signed [131:0] a, bit f);
    return f ? -a : a;
  endfunction

  function automatic bit unit_vector(logic signed [131:0] v [3], output logic [15:0] u [3]);
    logic [131:0] m [3];
    logic [63:0] s [3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    int top;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      for (int k = 0; k < 132; k++) if (m[i][k] && k + 1 > top) top = k + 1;
    end
    if (top == 0) return 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = top > 31 ? 64'(m[i] >> (top - 31)) : 64'(m[i] << (31 - top));
      sum += s[i] * s[i];
    end
    len = 0;
    for (int k = 31; k >= 0; k--) begin
      q = len | (64'd1 << k);
      if (q * q <= sum) len = q;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((s[i] << 15) + (len >> 1)) / len;
      if (q > 32767) q = 32767;
      u[i] = v[i] < 0 ? 16'(-q) : 16'(q);
    end
    return 1;
  endfunction

  function automatic void predict_vertex(logic [DW-1:0] d);
    logic signed [CW-1:0] p [5];
    logic signed [131:0] e1 [3], e2 [3], t [3], b [3];
    logic signed [131:0] d1u, d1v, d2u, d2v, det;
    frame_t f;
    for (int i = 0; i < 5; i++) p[i] = d[i*CW +: CW];
    if (slot == 0) begin
      held_a = p;
      slot = 1;
      return;
    end
    if (slot == 1) begin
      held_b = p;
      slot = 2;
      return;
    end
    slot = 0;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 132'(held_b[i]) - 132'(held_a[i]);
      e2[i] = 132'(p[i]) - 132'(held_a[i]);
    end
    d1u = 132'(held_b[3]) - 132'(held_a[3]);
    d1v = 132'(held_b[4]) - 132'(held_a[4]);
    d2u = 132'(p[3]) - 132'(held_a[3]);
    d2v = 132'(p[4]) - 132'(held_a[4]);
    det = d1u * d2v - d2u * d1v;
    for (int i = 0; i < 3; i++) begin
      t[i] = flip_if(d2v * e1[i] - d1v * e2[i], det < 0);
      b[i] = flip_if(d1u * e2[i] - d2u * e1[i], det < 0);
      f.tan[i] = 0;
      f.bin[i] = 0;
    end
    f.degen = 1;
    if (det != 0 && unit_vector(t, f.tan) && unit_vector(b, f.bin)) f.degen = 0;
    if (f.degen) for (int i = 0; i < 3; i++) begin
      f.tan[i] = 0;
      f.bin[i] = 0;
    end
    frame_q = {frame_q, f};
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 49) == 0) return $urandom_range(0, 40);
    return $urandom_range(0, gap_max);
  endfunction

  task automatic send_vertex(logic signed [CW-1:0] px, py, pz, tu, tv);
    logic [DW-1:0] d;
    int gap;
    d = '0;
    d[0 +: CW] = px;
    d[CW +: CW] = py;
    d[2*CW +: CW] = pz;
    d[3*CW +: CW] = tu;
    d[4*CW +: CW] = tv;
    s_tvalid <= 1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    predict_vertex(d);
    gap = (gap_max > 0) ? rand_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 0;
      idle_cycles(gap);
    end
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      2: return $signed(32'($urandom_range(0, 8)) - 32'd4);
      default: return $signed($urandom) >>> $urandom_range(0, 24);
    endcase
  endfunction

  task automatic send_random_vertex();
    send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (frame_q.size() != 0) @(posedge clk);
    idle_cycles(600);
  endtask

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      if (frame_q.size() == 0) begin
        $display("%0t: unexpected result %h %b", $time, m_tdata, m_tuser);
        errors++;
      end else begin
        frame_t f;
        f = frame_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[i*16 +: 16] !== f.tan[i]) begin
            $display("%0t: tan[%0d] expected %h actual %h", $time, i, f.tan[i],
                     m_tdata[i*16 +: 16]);
            errors++;
          end
          if (m_tdata[(3+i)*16 +: 16] !== f.bin[i]) begin
            $display("%0t: bit[%0d] expected %h actual %h", $time, i, f.bin[i],
                     m_tdata[(3+i)*16 +: 16]);
            errors++;
          end
        end
        if (m_tuser !== f.degen) begin
          $display("%0t: degenerate expected %b actual %b", $time, f.degen, m_tuser);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (gap_max == 0) begin
      m_tready <= 1;
    end else begin
      m_tready <= $urandom_range(0, 3) != 0;
    end
  end

  task automatic test_directed();
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'sh10000, 0, 0, 32'sh10000, 0);
    send_vertex(0, 32'sh10000, 0, 0, 32'sh10000);
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(0, 32'sh10000, 0, 0, 32'sh10000);
    send_vertex(32'sh10000, 0, 0, 32'sh10000, 0);
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'sh10000, 0, 0, 32'sh10000, 0);
    send_vertex(32'sh20000, 0, 0, 32'sh20000, 0);
    send_vertex(5, 5, 5, 0, 0);
    send_vertex(5, 5, 5, 32'sh10000, 0);
    send_vertex(5, 5, 5, 0, 32'sh10000);
    send_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_vertex(-1, -1, -1, -1, -1);
    send_vertex(1, 1, 1, 1, 1);
    send_vertex(1, 0, 0, 0, 0);
    send_vertex(-1, 0, 0, 1, 0);
    send_vertex(0, 1, 0, 0, 1);
  endtask

  task automatic test_random();
    repeat (1400) send_random_vertex();
  endtask

  task automatic test_output_stall();
    gap_max = 0;
    hold_off = 3000;
    repeat (12) send_random_vertex();
    gap_max = 3;
    drain();
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    repeat (60) send_random_vertex();
    gap_max = 3;
  endtask

  initial begin
    idle_cycles(5);
    rst <= 0;
    @(posedge clk);
    test_directed();
    drain();
    test_random();
    test_output_stall();
    test_back_to_back();
    drain();
    if (errors == 0) begin
      $display("triangle_tangent_bitangent_unit test passed");
    end else begin
      $display("triangle_tangent_bitangent_unit test failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("triangle_tangent_bitangent_unit test failed");
    $finish;
  end
endmodule
